// File: sv/cfse_pkg.sv
// Package for the command frame stuffing encoder.
// Holds the framing constants, the payload record type and the queue status struct.
// No dependencies.
package cfse_pkg;

  // Framing marks
  localparam logic [7:0] HeadMark = 8'h7D;
  localparam logic [7:0] EscMark  = 8'h7E;
  localparam logic [7:0] EscFlip  = 8'h20;

  // Payload tag bits of the first byte of each frame
  localparam logic [7:0] MotionTag = 8'hE0;
  localparam logic [7:0] CalTag    = 8'h20;
  localparam logic [7:0] KickTag   = 8'h40;

  // Payload bytes of all three frames, motion first
  localparam int unsigned PayBytes = 13;
  localparam int unsigned IdxW     = $clog2(PayBytes);

  // Command queue depth default
  localparam int unsigned QDepthDef = 2;

  // Stream widths
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 8;

  // Register map
  localparam int unsigned PaddrW = 3;
  localparam logic [0:0]  RegMotionStop = 1'b0;

  // Frame codes
  localparam logic [1:0] FrameMotion = 2'd0;
  localparam logic [1:0] FrameCal    = 2'd1;
  localparam logic [1:0] FrameKick   = 2'd2;

  typedef logic [PayBytes-1:0][7:0] pay_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Flat payload index of the last byte of a frame
  function automatic logic [IdxW-1:0] frame_last_idx(input logic [1:0] frame);
    logic [IdxW-1:0] res;
    unique case (frame)
      FrameMotion: res = IdxW'(7);
      FrameCal:    res = IdxW'(9);
      default:     res = IdxW'(PayBytes - 1);
    endcase
    return res;
  endfunction

endpackage

// File: sv/cfse_front.sv
// Front end: configuration register, command acceptance and payload packing.
// Depends on cfse_pkg; feeds cfse_queue.
module cfse_front import cfse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB-style configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Command stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] x_speed, [31:16] y_speed, [47:32] spin_rate, [56:48] heading_deg,
  // [65:57] orientation_deg, [66] kick_request, [71:67] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Queue side
  input  q_stat_t             qstat_i,
  output logic                push_o,
  output pay_rec_t            wr_data_o
);

  logic        stop_q, stop_d;
  logic        reg_sel;
  logic [15:0] x, y, w;
  logic [8:0]  h, o;
  logic        kick;

  // Decode the register word index
  assign reg_sel = (paddr[PaddrW-1:2] == RegMotionStop);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {31'b0, stop_q} : 32'b0;

  // Write the stop register on a completed write transaction
  always_comb begin
    stop_d = stop_q;
    if (psel && penable && pwrite && reg_sel) begin
      stop_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= 1'b0;
    end else begin
      stop_q <= stop_d;
    end
  end

  // Accept while the queue has room
  assign s_axis_tready = !qstat_i.full;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  // Unpack fields, zero the motion fields when stopped
  assign x    = stop_q ? 16'd0 : s_axis_tdata[15:0];
  assign y    = stop_q ? 16'd0 : s_axis_tdata[31:16];
  assign w    = stop_q ? 16'd0 : s_axis_tdata[47:32];
  assign h    = stop_q ? 9'd0  : s_axis_tdata[56:48];
  assign o    = s_axis_tdata[65:57];
  assign kick = s_axis_tdata[66];

  // Pack the three frame payloads, each value masked to its slot
  always_comb begin
    wr_data_o[0]  = MotionTag | {3'b000, x[15:11]};
    wr_data_o[1]  = x[10:3];
    wr_data_o[2]  = {x[2:0], y[15:11]};
    wr_data_o[3]  = y[10:3];
    wr_data_o[4]  = {y[2:0], 3'b000, h[8:7]};
    wr_data_o[5]  = {h[6:0], 1'b0};
    wr_data_o[6]  = w[15:8];
    wr_data_o[7]  = w[7:0];
    wr_data_o[8]  = CalTag | {7'b0, o[8]};
    wr_data_o[9]  = o[7:0];
    wr_data_o[10] = KickTag | {4'b0, kick, 3'b000};
    wr_data_o[11] = 8'h00;
    wr_data_o[12] = 8'h00;
  end

endmodule

// File: sv/cfse_queue.sv
// Short command queue between the front end and the frame serializer.
// Depends on cfse_pkg for the payload record and status types.
module cfse_queue import cfse_pkg::*; #(
  parameter int unsigned Depth = QDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pay_rec_t wr_data_i,
  input  logic     pop_i,
  output pay_rec_t rd_data_o,
  output q_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pay_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign rd_data_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: sv/cfse_back.sv
// Back end: walks one command record through its three frames, inserting
// escapes and the checksum, one serial byte per step. Depends on cfse_pkg.
module cfse_back import cfse_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Queue side
  input  q_stat_t              qstat_i,
  input  pay_rec_t             rd_data_i,
  output logic                 pop_o,
  // Byte stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] tx_byte
  output logic [OutDataW-1:0]  m_axis_tdata,
  // [0] frame_end
  output logic [0:0]           m_axis_tuser,
  output logic                 m_axis_tlast
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StHead  = 4'b0010,
    StPay   = 4'b0100,
    StCksum = 4'b1000
  } st_e;

  st_e             state_q, state_d;
  pay_rec_t        rec_q, rec_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [1:0]      frame_q, frame_d;
  logic            esc_q, esc_d;
  logic [7:0]      sum_q, sum_d;
  logic            ovalid_q, ovalid_d;
  logic [7:0]      tdata_q, tdata_d;
  logic            fend_q, fend_d;
  logic            last_q, last_d;
  logic            step;
  logic [7:0]      raw;
  logic [7:0]      flipped;
  logic            esc_need;

  // Step when there is work and the output register is free or being drained
  assign step  = (state_q != StIdle) && (!ovalid_q || m_axis_tready);
  assign pop_o = (state_q == StIdle) && !qstat_i.empty;

  // Byte under consideration and its stuffing
  always_comb begin
    unique case (state_q)
      StPay:   raw = rec_q[idx_q];
      StCksum: raw = sum_q;
      default: raw = HeadMark;
    endcase
    esc_need = !esc_q && (raw == HeadMark || raw == EscMark);
    flipped  = esc_q ? (raw ^ EscFlip) : raw;
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    rec_d    = rec_q;
    idx_d    = idx_q;
    frame_d  = frame_q;
    esc_d    = esc_q;
    sum_d    = sum_q;
    tdata_d  = tdata_q;
    fend_d   = fend_q;
    last_d   = last_q;
    ovalid_d = m_axis_tready ? 1'b0 : ovalid_q;

    if (step) begin
      ovalid_d = 1'b1;
      fend_d   = 1'b0;
      last_d   = 1'b0;
      unique case (state_q)
        StHead: begin
          tdata_d = HeadMark;
          sum_d   = HeadMark;
          state_d = StPay;
        end
        StPay: begin
          if (esc_need) begin
            tdata_d = EscMark;
            esc_d   = 1'b1;
          end else begin
            tdata_d = flipped;
            esc_d   = 1'b0;
            sum_d   = sum_q + flipped;
            idx_d   = idx_q + IdxW'(1);
            if (idx_q == frame_last_idx(frame_q)) begin
              state_d = StCksum;
            end
          end
        end
        StCksum: begin
          if (esc_need) begin
            tdata_d = EscMark;
            esc_d   = 1'b1;
          end else begin
            tdata_d = flipped;
            esc_d   = 1'b0;
            fend_d  = 1'b1;
            if (frame_q == FrameKick) begin
              last_d  = 1'b1;
              state_d = StIdle;
            end else begin
              frame_d = frame_q + 2'd1;
              state_d = StHead;
            end
          end
        end
        default: ;
      endcase
    end else if (pop_o) begin
      // Load the next command record
      rec_d   = rd_data_i;
      idx_d   = '0;
      frame_d = FrameMotion;
      esc_d   = 1'b0;
      state_d = StHead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      idx_q    <= '0;
      frame_q  <= FrameMotion;
      esc_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      frame_q  <= frame_d;
      esc_q    <= esc_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q   <= rec_d;
    sum_q   <= sum_d;
    tdata_q <= tdata_d;
    fend_q  <= fend_d;
    last_q  <= last_d;
  end

  assign m_axis_tvalid   = ovalid_q;
  assign m_axis_tdata    = tdata_q;
  assign m_axis_tuser[0] = fend_q;
  assign m_axis_tlast    = last_q;

endmodule

// File: sv/command_frame_stuffing_encoder_unit.sv
// Command frame stuffing encoder: one command in, three stuffed frames out.
// With the serializer idle, a command is written into the queue, popped into the record
// register, and its first byte is then registered into the output register.
// Throughput: one byte per cycle while m_axis_tready is high, 19 to 29 bytes per
// command, set by the single byte serializer, which loads each record when idle.
// Reset: asynchronous, active low; clears motion_stop, the queue and the serializer.
module command_frame_stuffing_encoder_unit import cfse_pkg::*; #(
  parameter int unsigned QDepth = QDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB-style configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Command stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] x_speed, [31:16] y_speed, [47:32] spin_rate, [56:48] heading_deg,
  // [65:57] orientation_deg, [66] kick_request, [71:67] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Serial byte stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] tx_byte
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] frame_end
  output logic [0:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  q_stat_t  qstat;
  logic     push, pop;
  pay_rec_t wr_data, rd_data;

  cfse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .qstat_i       (qstat),
    .push_o        (push),
    .wr_data_o     (wr_data)
  );

  cfse_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_data),
    .pop_i     (pop),
    .rd_data_o (rd_data),
    .stat_o    (qstat)
  );

  cfse_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .rd_data_i     (rd_data),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
